// ===== rtl/core/sdpf_pkg.sv =====
// ----------------------------------------------------------------------------
// sdpf_pkg
// shared types, register indexes and saturation helpers for the disc pair
// force block
// ----------------------------------------------------------------------------
package sdpf_pkg;

	localparam int unsigned NUM_REGS = 5;

	typedef enum logic [2:0] {
		REG_BOX_WIDTH  = 3'd0,
		REG_BOX_HEIGHT = 3'd1,
		REG_SHEAR      = 3'd2,
		REG_STIFFNESS  = 3'd3,
		REG_DAMPING    = 3'd4
	} reg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DIFF,
		ST_WRAPX,
		ST_WRAPY,
		ST_WRAPX2,
		ST_CHK,
		ST_SQX,
		ST_SQY,
		ST_RR,
		ST_RCMP,
		ST_SQ_GO,
		ST_SQ,
		ST_DF_GO,
		ST_DF,
		ST_DX_GO,
		ST_DX,
		ST_DY_GO,
		ST_DY,
		ST_MLO,
		ST_MHI,
		ST_MFIN,
		ST_MST,
		ST_VSUM,
		ST_ACC,
		ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_FC,
		OP_VNX,
		OP_VNY,
		OP_FD,
		OP_DGX,
		OP_DGY,
		OP_CX,
		OP_CY,
		OP_SR,
		OP_FF,
		OP_E,
		OP_XX,
		OP_YY,
		OP_XY
	} op_t;

	function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) begin
			sat_add64 = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		end else begin
			sat_add64 = s[63:0];
		end
	endfunction

	function automatic logic [47:0] sat48(input logic signed [63:0] v);
		if (!v[63] && (|v[62:47])) begin
			sat48 = {1'b0, {47{1'b1}}};
		end else if (v[63] && !(&v[62:47])) begin
			sat48 = {1'b1, 47'd0};
		end else begin
			sat48 = v[47:0];
		end
	endfunction

endpackage

// ===== rtl/core/sdpf_umul.sv =====
// ----------------------------------------------------------------------------
// sdpf_umul
// shared 32x32 unsigned multiplier with registered product
// ----------------------------------------------------------------------------
module sdpf_umul (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] prod
);

	logic [63:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= 64'(a) * 64'(b);
	end

	assign prod = prod_q;

endmodule

// ===== rtl/core/sdpf_div.sv =====
// ----------------------------------------------------------------------------
// sdpf_div
// restoring divider, 64 by 32 bits, one quotient bit per cycle
// quotient must fit 32 bits (upper dividend half below divisor)
// ----------------------------------------------------------------------------
module sdpf_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quot
);

	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] d_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] trial;
	logic [33:0] diff;
	logic        ge;

	assign trial = {rem_q, quo_q[31]};
	assign diff  = {1'b0, trial} - {2'b00, d_q};
	assign ge    = !diff[33];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd31) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[63:32];
			quo_q <= dividend[31:0];
			d_q   <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[31:0] : trial[31:0];
			quo_q <= {quo_q[30:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

// ===== rtl/core/sdpf_isqrt.sv =====
// ----------------------------------------------------------------------------
// sdpf_isqrt
// digit-by-digit integer square root of a 64-bit value, one root bit a cycle
// ----------------------------------------------------------------------------
module sdpf_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic        done,
	output logic [31:0] root
);

	logic [63:0] v_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [35:0] cand;
	logic [35:0] trial;
	logic [36:0] diff;
	logic        ge;

	assign cand  = {rem_q, v_q[63:62]};
	assign trial = {2'b00, root_q, 2'b01};
	assign diff  = {1'b0, cand} - {1'b0, trial};
	assign ge    = !diff[36];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd31) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			v_q    <= {v_q[61:0], 2'b00};
			rem_q  <= ge ? diff[33:0] : cand[33:0];
			root_q <= {root_q[30:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ===== rtl/core/soft_disc_pair_force.sv =====
// ----------------------------------------------------------------------------
// soft_disc_pair_force
// hookean contact force and normal drag between two discs, sheared box
// ----------------------------------------------------------------------------
// One pair is worked on at a time. A pair that is skipped (absent disc, no
// overlap, coincident centres) skips the root, divider and product steps;
// a pair in contact takes one root bit per cycle in the square root unit
// and one quotient bit per cycle in the divider (used for the root, the
// overlap fraction and both normal components), then 14 products of up
// to 64x32 bits, each as two passes of the single 32x32 multiplier.
// Sums are cleared at transfer in when first_pair is set.
module soft_disc_pair_force
	import sdpf_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// pos_a_x, pos_a_y, pos_b_x, pos_b_y, vel_a_x, vel_a_y, vel_b_x, vel_b_y,
	// radius_a, radius_b, zero fill
	input  logic [319:0] s_tdata,
	// first_pair
	input  logic [0:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// force_x, force_y, drag_x, drag_y, energy_sum, virial_sum, virial_xx,
	// virial_yy, virial_xy
	output logic [511:0] m_tdata,
	// contact
	output logic [0:0]   m_tuser,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	state_t state_q, state_d;
	op_t    op_q;

	logic [30:0]        box_w_q, box_h_q, stiff_q, damp_q;
	logic signed [31:0] shear_q;

	logic [319:0]       din_q;
	logic signed [35:0] dx_q, dy_q;
	logic signed [32:0] vrx_q, vry_q;
	logic [31:0]        rsum_q;
	logic               up_q, dn_q;
	logic [31:0]        mx_q, my_q;
	logic [63:0]        sqx_q;
	logic [64:0]        rr_q;
	logic [31:0]        r_q, frac_q;
	logic [30:0]        ux_q, uy_q;
	logic [63:0]        lo_q;
	logic signed [63:0] res_q;
	logic [31:0]        fc_q, ff_q;
	logic [62:0]        sr_q;
	logic signed [63:0] t1_q, vn_q, fd_q, dgx_q, dgy_q, tx_q, ty_q, e_q;
	logic signed [63:0] xx_q, yy_q, xy_q, vs_q;
	logic signed [63:0] acc_e_q, acc_v_q, acc_xx_q, acc_yy_q, acc_xy_q;
	logic               contact_q;
	logic               m_tvalid_q;
	logic [511:0]       m_tdata_q;
	logic               m_tuser_q;

	logic [31:0]        mul_a, mul_b;
	logic [63:0]        prod;
	logic               sq_start, sq_done;
	logic [31:0]        sq_root;
	logic               div_start, div_done;
	logic [63:0]        div_n;
	logic [31:0]        div_d, div_q;

	logic signed [35:0] hw, hh, wd, ht;
	logic [35:0]        dx_mag, dy_mag;
	logic               in_box;
	logic [63:0]        op_a;
	logic [31:0]        op_b;
	logic [6:0]         op_sh;
	logic               op_neg;
	logic [95:0]        p96, pm;
	logic [62:0]        mclamp;
	logic [63:0]        mres;
	logic               out_load;

	sdpf_umul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	sdpf_isqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (rr_q[63:0]),
		.done     (sq_done),
		.root     (sq_root)
	);

	sdpf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_n),
		.divisor  (div_d),
		.done     (div_done),
		.quot     (div_q)
	);

	assign hw = $signed({6'd0, box_w_q[30:1]});
	assign hh = $signed({6'd0, box_h_q[30:1]});
	assign wd = $signed({5'd0, box_w_q});
	assign ht = $signed({5'd0, box_h_q});

	assign dx_mag = dx_q[35] ? 36'(-dx_q) : 36'(dx_q);
	assign dy_mag = dy_q[35] ? 36'(-dy_q) : 36'(dy_q);
	assign in_box = (|din_q[286:256]) && (|din_q[317:287])
		&& (dx_mag < {4'd0, rsum_q}) && (dy_mag < {4'd0, rsum_q});

	// operands of the shared signed product step
	always_comb begin
		op_a   = '0;
		op_b   = '0;
		op_sh  = 7'd0;
		op_neg = 1'b0;
		unique case (op_q)
			OP_FC: begin
				op_a  = {33'd0, stiff_q};
				op_b  = frac_q;
				op_sh = 7'd32;
			end
			OP_VNX: begin
				op_a   = {31'd0, (vrx_q[32] ? 33'(-vrx_q) : 33'(vrx_q))};
				op_b   = {1'b0, ux_q};
				op_sh  = 7'd30;
				op_neg = vrx_q[32] ^ dx_q[35];
			end
			OP_VNY: begin
				op_a   = {31'd0, (vry_q[32] ? 33'(-vry_q) : 33'(vry_q))};
				op_b   = {1'b0, uy_q};
				op_sh  = 7'd30;
				op_neg = vry_q[32] ^ dy_q[35];
			end
			OP_FD: begin
				op_a   = vn_q[63] ? 64'(-vn_q) : 64'(vn_q);
				op_b   = {1'b0, damp_q};
				op_sh  = 7'd16;
				op_neg = !vn_q[63];
			end
			OP_DGX: begin
				op_a   = fd_q[63] ? 64'(-fd_q) : 64'(fd_q);
				op_b   = {1'b0, ux_q};
				op_sh  = 7'd30;
				op_neg = fd_q[63] ^ dx_q[35];
			end
			OP_DGY: begin
				op_a   = fd_q[63] ? 64'(-fd_q) : 64'(fd_q);
				op_b   = {1'b0, uy_q};
				op_sh  = 7'd30;
				op_neg = fd_q[63] ^ dy_q[35];
			end
			OP_CX: begin
				op_a   = {33'd0, ux_q};
				op_b   = fc_q;
				op_sh  = 7'd30;
				op_neg = dx_q[35];
			end
			OP_CY: begin
				op_a   = {33'd0, uy_q};
				op_b   = fc_q;
				op_sh  = 7'd30;
				op_neg = dy_q[35];
			end
			OP_SR: begin
				op_a = {33'd0, stiff_q};
				op_b = rsum_q;
			end
			OP_FF: begin
				op_a  = {32'd0, frac_q};
				op_b  = frac_q;
				op_sh = 7'd32;
			end
			OP_E: begin
				op_a  = {1'b0, sr_q};
				op_b  = ff_q;
				op_sh = 7'd32;
			end
			OP_XX: begin
				op_a   = tx_q[63] ? 64'(-tx_q) : 64'(tx_q);
				op_b   = mx_q;
				op_sh  = 7'd1;
				op_neg = tx_q[63] ^ dx_q[35];
			end
			OP_YY: begin
				op_a   = ty_q[63] ? 64'(-ty_q) : 64'(ty_q);
				op_b   = my_q;
				op_sh  = 7'd1;
				op_neg = ty_q[63] ^ dy_q[35];
			end
			OP_XY: begin
				op_a   = tx_q[63] ? 64'(-tx_q) : 64'(tx_q);
				op_b   = my_q;
				op_sh  = 7'd1;
				op_neg = tx_q[63] ^ dy_q[35];
			end
			default: begin
				op_a = '0;
			end
		endcase
	end

	// full product from the two partial passes, then shift and clamp
	assign p96    = {prod, 32'd0} + {32'd0, lo_q};
	assign pm     = p96 >> op_sh;
	assign mclamp = (|pm[95:63]) ? {63{1'b1}} : pm[62:0];
	assign mres   = op_neg ? (64'd0 - {1'b0, mclamp}) : {1'b0, mclamp};

	assign out_load = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (s_tvalid) state_d = ST_DIFF;
			ST_DIFF:   state_d = ST_WRAPX;
			ST_WRAPX:  state_d = ST_WRAPY;
			ST_WRAPY:  state_d = ST_WRAPX2;
			ST_WRAPX2: state_d = ST_CHK;
			ST_CHK:    state_d = in_box ? ST_SQX : ST_DONE;
			ST_SQX:    state_d = ST_SQY;
			ST_SQY:    state_d = ST_RR;
			ST_RR:     state_d = ST_RCMP;
			ST_RCMP: begin
				if (!rr_q[64] && (rr_q[63:0] < prod) && (|rr_q[63:0])) begin
					state_d = ST_SQ_GO;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_SQ_GO:  state_d = ST_SQ;
			ST_SQ:     if (sq_done) state_d = ST_DF_GO;
			ST_DF_GO:  state_d = ST_DF;
			ST_DF:     if (div_done) state_d = ST_DX_GO;
			ST_DX_GO:  state_d = ST_DX;
			ST_DX:     if (div_done) state_d = ST_DY_GO;
			ST_DY_GO:  state_d = ST_DY;
			ST_DY:     if (div_done) state_d = ST_MLO;
			ST_MLO:    state_d = ST_MHI;
			ST_MHI:    state_d = ST_MFIN;
			ST_MFIN:   state_d = ST_MST;
			ST_MST:    state_d = (op_q == OP_XY) ? ST_VSUM : ST_MLO;
			ST_VSUM:   state_d = ST_ACC;
			ST_ACC:    state_d = ST_DONE;
			ST_DONE:   if (out_load) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// unit control and multiplier operands
	always_comb begin
		s_tready  = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		sq_start  = 1'b0;
		div_start = 1'b0;
		div_n     = '0;
		div_d     = '0;
		unique case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_SQX: begin
				mul_a = mx_q;
				mul_b = mx_q;
			end
			ST_SQY: begin
				mul_a = my_q;
				mul_b = my_q;
			end
			ST_RR: begin
				mul_a = rsum_q;
				mul_b = rsum_q;
			end
			ST_SQ_GO: sq_start = 1'b1;
			ST_DF_GO: begin
				div_start = 1'b1;
				div_n     = {rsum_q - r_q, 32'd0};
				div_d     = rsum_q;
			end
			ST_DX_GO: begin
				div_start = 1'b1;
				div_n     = {2'b00, mx_q, 30'd0};
				div_d     = r_q;
			end
			ST_DY_GO: begin
				div_start = 1'b1;
				div_n     = {2'b00, my_q, 30'd0};
				div_d     = r_q;
			end
			ST_MLO: begin
				mul_a = op_a[31:0];
				mul_b = op_b;
			end
			ST_MHI: begin
				mul_a = op_a[63:32];
				mul_b = op_b;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			op_q       <= OP_FC;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DY) begin
				op_q <= OP_FC;
			end else if (state_q == ST_MST && op_q != OP_XY) begin
				op_q <= op_t'(op_q + 4'd1);
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_w_q <= 31'd6553600;
			box_h_q <= 31'd6553600;
			shear_q <= '0;
			stiff_q <= 31'd65536;
			damp_q  <= 31'd65536;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BOX_WIDTH:  box_w_q <= cfg_data[30:0];
				REG_BOX_HEIGHT: box_h_q <= cfg_data[30:0];
				REG_SHEAR:      shear_q <= cfg_data;
				REG_STIFFNESS:  stiff_q <= cfg_data[30:0];
				REG_DAMPING:    damp_q  <= cfg_data[30:0];
				default:        ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_e_q  <= '0;
			acc_v_q  <= '0;
			acc_xx_q <= '0;
			acc_yy_q <= '0;
			acc_xy_q <= '0;
		end else if (state_q == ST_IDLE && s_tvalid && s_tuser[0]) begin
			acc_e_q  <= '0;
			acc_v_q  <= '0;
			acc_xx_q <= '0;
			acc_yy_q <= '0;
			acc_xy_q <= '0;
		end else if (state_q == ST_ACC) begin
			acc_e_q  <= sat_add64(acc_e_q, e_q);
			acc_v_q  <= sat_add64(acc_v_q, vs_q);
			acc_xx_q <= sat_add64(acc_xx_q, xx_q);
			acc_yy_q <= sat_add64(acc_yy_q, yy_q);
			acc_xy_q <= sat_add64(acc_xy_q, xy_q);
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				din_q     <= s_tdata;
				contact_q <= 1'b0;
				tx_q      <= '0;
				ty_q      <= '0;
				dgx_q     <= '0;
				dgy_q     <= '0;
			end
			ST_DIFF: begin
				dx_q   <= {{4{din_q[31]}}, din_q[31:0]} - {{4{din_q[95]}}, din_q[95:64]};
				dy_q   <= {{4{din_q[63]}}, din_q[63:32]} - {{4{din_q[127]}}, din_q[127:96]};
				vrx_q  <= {din_q[159], din_q[159:128]} - {din_q[223], din_q[223:192]};
				vry_q  <= {din_q[191], din_q[191:160]} - {din_q[255], din_q[255:224]};
				rsum_q <= {1'b0, din_q[286:256]} + {1'b0, din_q[317:287]};
			end
			ST_WRAPX: begin
				if (dx_q >= hw) begin
					dx_q <= dx_q - wd;
				end else if (dx_q < -hw) begin
					dx_q <= dx_q + wd;
				end
			end
			ST_WRAPY: begin
				// crossing the sheared boundary moves x by the shear offset
				if (dy_q >= hh) begin
					dx_q <= dx_q - 36'(shear_q);
					dy_q <= dy_q - ht;
					up_q <= 1'b1;
					dn_q <= 1'b0;
				end else if (dy_q < -hh) begin
					dx_q <= dx_q + 36'(shear_q);
					dy_q <= dy_q + ht;
					up_q <= 1'b0;
					dn_q <= 1'b1;
				end else begin
					up_q <= 1'b0;
					dn_q <= 1'b0;
				end
			end
			ST_WRAPX2: begin
				if (up_q && dx_q < -hw) begin
					dx_q <= dx_q + wd;
				end else if (dn_q && dx_q >= hw) begin
					dx_q <= dx_q - wd;
				end
			end
			ST_CHK: begin
				mx_q <= dx_mag[31:0];
				my_q <= dy_mag[31:0];
			end
			ST_SQY: sqx_q <= prod;
			ST_RR:  rr_q  <= {1'b0, sqx_q} + {1'b0, prod};
			ST_SQ:  if (sq_done) r_q <= sq_root;
			ST_DF:  if (div_done) frac_q <= div_q;
			ST_DX:  if (div_done) ux_q <= div_q[30:0];
			ST_DY:  if (div_done) uy_q <= div_q[30:0];
			ST_MHI: lo_q  <= prod;
			ST_MFIN: res_q <= mres;
			ST_MST: begin
				unique case (op_q)
					OP_FC:   fc_q  <= res_q[31:0];
					OP_VNX:  t1_q  <= res_q;
					OP_VNY:  vn_q  <= t1_q + res_q;
					OP_FD:   fd_q  <= res_q;
					OP_DGX:  dgx_q <= res_q;
					OP_DGY:  dgy_q <= res_q;
					OP_CX:   tx_q  <= res_q + dgx_q;
					OP_CY:   ty_q  <= res_q + dgy_q;
					OP_SR:   sr_q  <= res_q[62:0];
					OP_FF:   ff_q  <= res_q[31:0];
					OP_E:    e_q   <= res_q >>> 2;
					OP_XX:   xx_q  <= res_q;
					OP_YY:   yy_q  <= res_q;
					OP_XY:   xy_q  <= res_q;
					default: ;
				endcase
			end
			ST_VSUM: vs_q <= sat_add64(xx_q, yy_q);
			ST_ACC:  contact_q <= 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tuser_q <= contact_q;
			m_tdata_q <= {acc_xy_q, acc_yy_q, acc_xx_q, acc_v_q, acc_e_q,
				sat48(dgy_q), sat48(dgx_q), sat48(ty_q), sat48(tx_q)};
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_tuser_q;

endmodule
